/* sv/lms_pkg.sv */
// ----------------------------------------------------------------------------
// Laplacian mesh smoother package
// Shared types, codes and constants of the mesh smoother.
// ----------------------------------------------------------------------------
package lms_pkg;

  localparam int unsigned MaxVerticesDef = 1024;
  localparam int unsigned MaxEdgesDef    = 4096;
  localparam int unsigned FracBits       = 14;
  localparam logic [15:0] LambdaReset    = 16'd8192;
  localparam logic [7:0]  SweepReset     = 8'd1;
  localparam logic [2:0]  HullRegions    = 3'd2;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_EDGE  = 2'd1,
    KIND_RUN   = 2'd2,
    KIND_READ  = 2'd3
  } lms_kind_e;

  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_LAMBDA = 2'd1,
    CFG_SWEEPS = 2'd2,
    CFG_VCOUNT = 2'd3
  } lms_cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CLR,
    ST_E_RD,
    ST_E_POS,
    ST_E_ACCA,
    ST_E_ACCB,
    ST_V_RD,
    ST_V_CHK,
    ST_V_MLO,
    ST_V_MHI,
    ST_V_DIV,
    ST_V_WAIT,
    ST_V_WR,
    ST_DONE
  } lms_state_e;

  typedef struct packed {
    logic        [1:0]  kind;
    logic        [9:0]  vertex_index;
    logic        [9:0]  other_vertex;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               on_boundary;
    logic        [2:0]  region_count;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic        [9:0]  out_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               bnd;
    logic        [2:0]  regions;
  } vtx_t;

endpackage

/* sv/lms_div.sv */
// ----------------------------------------------------------------------------
// Mesh smoother divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lms_div #(
  parameter int unsigned NW = 49,
  parameter int unsigned DW = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [DW-1:0] dvs_q;
  logic [DW:0]   rem_q;
  logic [NW-1:0] quo_q;
  logic [DW:0]   trial;
  logic          take;

  assign trial = {rem_q[DW-1:0], quo_q[NW-1]};
  assign take  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? (trial - {1'b0, dvs_q}) : trial;
      quo_q <= {quo_q[NW-2:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef SYNTH
  a_busy_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (cnt_q != '0)) else $error("divider count out of step");
  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without work");
  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
`endif

endmodule

/* sv/laplacian_mesh_smoother_top.sv */
// ----------------------------------------------------------------------------
// Laplacian mesh smoother
// Stores vertices and edges in on-chip memories and runs Jacobi sweeps.
// ----------------------------------------------------------------------------
//   channel | signals                     | beat
//   in      | in_valid_i, in_stall_o      | one command
//   out     | out_valid_o, out_stall_i    | read data or run finished
//   cfg     | cfg_valid_i, cfg_ready_o    | one register write
//
// Vertex and edge loads can follow one another while idle; a read passes through ST_READ.
// A run makes each sweep in turn: clear the accumulators, add up the edges,
// then move each movable vertex through the shared bit-serial divider, whose
// width NW is 49 by default. That divider and the single write port of each
// memory pace a run. Reset clears control state only; memories start undefined.
// The output register holds a beat under out_stall_i while loads go on.
module laplacian_mesh_smoother_top #(
  parameter int unsigned MAX_VERTICES = lms_pkg::MaxVerticesDef,
  parameter int unsigned MAX_EDGES    = lms_pkg::MaxEdgesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lms_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lms_pkg::out_item_t out_item_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);
  import lms_pkg::*;

  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned EAW = $clog2(MAX_EDGES);
  localparam int unsigned EW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned DW  = EW;
  localparam int unsigned AW  = 33 + DW;
  localparam int unsigned PW  = AW + 16;
  localparam int unsigned NW  = PW + 1 - FracBits;
  localparam int unsigned SW  = NW + 2;
  localparam int unsigned RW  = 3 * AW + DW;
  localparam logic signed [SW-1:0] SMax = SW'(2147483647);
  localparam logic signed [SW-1:0] SMin = -SMax - SW'(1);

  lms_state_e state_q, state_d;

  logic              mode_q;
  logic signed [15:0] lam_q;
  logic [7:0]        sweeps_q;
  logic [10:0]       vcount_q;
  logic [EW-1:0]     edges_q;
  logic [7:0]        sweep_left_q;
  logic [VW:0]       vtx_q;
  logic [EW-1:0]     edge_q;
  logic [1:0]        coord_q;
  logic              out_valid_q;
  out_item_t         out_item_q;
  logic [9:0]        rd_idx_q;
  logic              rd_ok_q;
  logic [39:0]       plo_q;
  logic [PW-1:0]     prod_q;
  logic              neg_q;
  logic signed [31:0] new_x_q, new_y_q, new_z_q;

  vtx_t              pos_mem [MAX_VERTICES];
  logic [RW-1:0]     acc_mem [MAX_VERTICES];
  logic [19:0]       edge_mem [MAX_EDGES];
  vtx_t              pos_rd0_q, pos_rd1_q;
  logic [RW-1:0]     acc_rd_q;
  logic [19:0]       edge_rd_q;

  logic [VW-1:0]     pos_ra0, pos_ra1, acc_ra, pos_wa, acc_wa;
  logic              pos_we, acc_we;
  vtx_t              pos_wd;
  logic [RW-1:0]     acc_wd;

  logic              in_acc;
  logic [VW:0]       nv;
  logic [9:0]        ea, eb;
  logic              edge_ok;
  logic              in_range;
  logic signed [AW-1:0] ax, ay, az, acc_c;
  logic [DW-1:0]     deg;
  logic signed [32:0] dx, dy, dz;
  logic [AW-1:0]     mag;
  logic [15:0]       lam_mag;
  logic signed [31:0] old_c;
  logic              movable;
  logic [PW:0]       dsum;
  logic              div_start, div_done;
  logic [NW-1:0]     div_q;
  logic signed [SW-1:0] rsum, roff;
  logic signed [31:0] rsat;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE) ||
                       (out_valid_q && (in_item_i.kind == KIND_RUN ||
                                        in_item_i.kind == KIND_READ));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_range    = 32'(in_item_i.vertex_index) < 32'(MAX_VERTICES);
  assign nv          = (32'(vcount_q) > 32'(MAX_VERTICES)) ? (VW + 1)'(MAX_VERTICES)
                                                           : (VW + 1)'(vcount_q);
  assign ea          = edge_rd_q[9:0];
  assign eb          = edge_rd_q[19:10];
  assign edge_ok     = (32'(ea) < 32'(nv)) && (32'(eb) < 32'(nv)) && (ea != eb);

  assign ax  = acc_rd_q[AW-1:0];
  assign ay  = acc_rd_q[2*AW-1:AW];
  assign az  = acc_rd_q[3*AW-1:2*AW];
  assign deg = acc_rd_q[RW-1:3*AW];
  assign dx  = 33'(pos_rd1_q.x) - 33'(pos_rd0_q.x);
  assign dy  = 33'(pos_rd1_q.y) - 33'(pos_rd0_q.y);
  assign dz  = 33'(pos_rd1_q.z) - 33'(pos_rd0_q.z);
  assign movable = mode_q ? (pos_rd0_q.regions == HullRegions) : !pos_rd0_q.bnd;

  always_comb begin
    case (coord_q)
      2'd0: begin
        acc_c = ax;
        old_c = pos_rd0_q.x;
      end
      2'd1: begin
        acc_c = ay;
        old_c = pos_rd0_q.y;
      end
      default: begin
        acc_c = az;
        old_c = pos_rd0_q.z;
      end
    endcase
  end

  assign mag     = acc_c[AW-1] ? AW'(-acc_c) : AW'(acc_c);
  assign lam_mag = lam_q[15] ? 16'(-lam_q) : 16'(lam_q);
  assign dsum    = (PW + 1)'(prod_q) + ((PW + 1)'(deg) << (FracBits - 1));
  assign roff    = neg_q ? -SW'(div_q) : SW'(div_q);
  assign rsum    = SW'(old_c) + roff;
  assign rsat    = (rsum > SMax) ? 32'sh7fffffff :
                   (rsum < SMin) ? 32'sh80000000 : 32'(rsum);
  assign div_start = state_q == ST_V_DIV;

  lms_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(NW'(dsum >> FracBits)),
    .divisor_i (deg),
    .done_o    (div_done),
    .quotient_o(div_q)
  );

  always_comb begin
    pos_ra0 = vtx_q[VW-1:0];
    pos_ra1 = VW'(eb);
    acc_ra  = vtx_q[VW-1:0];
    pos_we  = 1'b0;
    pos_wa  = vtx_q[VW-1:0];
    pos_wd  = '{x: new_x_q, y: new_y_q, z: new_z_q, bnd: pos_rd0_q.bnd,
                regions: pos_rd0_q.regions};
    acc_we  = 1'b0;
    acc_wa  = vtx_q[VW-1:0];
    acc_wd  = '0;
    unique case (state_q)
      ST_IDLE: begin
        pos_ra0 = VW'(in_item_i.vertex_index);
        if (in_acc && in_item_i.kind == KIND_WRITE && in_range) begin
          pos_we = 1'b1;
          pos_wa = VW'(in_item_i.vertex_index);
          pos_wd = '{x: in_item_i.coord_x, y: in_item_i.coord_y,
                     z: in_item_i.coord_z, bnd: in_item_i.on_boundary,
                     regions: in_item_i.region_count};
        end
      end
      ST_CLR: begin
        acc_we = vtx_q < nv;
      end
      ST_E_POS: begin
        pos_ra0 = VW'(ea);
        acc_ra  = VW'(ea);
      end
      ST_E_ACCA: begin
        pos_ra0 = VW'(ea);
        acc_ra  = VW'(eb);
        acc_we  = 1'b1;
        acc_wa  = VW'(ea);
        acc_wd  = {DW'(deg + DW'(1)), AW'(az + AW'(dz)), AW'(ay + AW'(dy)),
                   AW'(ax + AW'(dx))};
      end
      ST_E_ACCB: begin
        pos_ra0 = VW'(ea);
        acc_ra  = VW'(eb);
        acc_we  = 1'b1;
        acc_wa  = VW'(eb);
        acc_wd  = {DW'(deg + DW'(1)), AW'(az - AW'(dz)), AW'(ay - AW'(dy)),
                   AW'(ax - AW'(dx))};
      end
      ST_V_WR: begin
        pos_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    pos_rd0_q <= pos_mem[pos_ra0];
    pos_rd1_q <= pos_mem[pos_ra1];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    acc_rd_q <= acc_mem[acc_ra];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_item_i.kind == KIND_EDGE && 32'(edges_q) < 32'(MAX_EDGES)) begin
      edge_mem[edges_q[EAW-1:0]] <= {in_item_i.other_vertex, in_item_i.vertex_index};
    end
    edge_rd_q <= edge_mem[edge_q[EAW-1:0]];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_item_i.kind == KIND_RUN) begin
          state_d = (sweeps_q == '0) ? ST_DONE : ST_CLR;
        end else if (in_acc && in_item_i.kind == KIND_READ) begin
          state_d = ST_READ;
        end
      end
      ST_READ:   state_d = ST_IDLE;
      ST_CLR:    if (vtx_q >= nv) state_d = ST_E_RD;
      ST_E_RD:   state_d = (edge_q < edges_q) ? ST_E_POS : ST_V_RD;
      ST_E_POS:  state_d = edge_ok ? ST_E_ACCA : ST_E_RD;
      ST_E_ACCA: state_d = ST_E_ACCB;
      ST_E_ACCB: state_d = ST_E_RD;
      ST_V_RD: begin
        if (vtx_q < nv) begin
          state_d = ST_V_CHK;
        end else begin
          state_d = (sweep_left_q == 8'd1) ? ST_DONE : ST_CLR;
        end
      end
      ST_V_CHK:  state_d = (movable && deg != '0) ? ST_V_MLO : ST_V_RD;
      ST_V_MLO:  state_d = ST_V_MHI;
      ST_V_MHI:  state_d = ST_V_DIV;
      ST_V_DIV:  state_d = ST_V_WAIT;
      ST_V_WAIT: if (div_done) state_d = (coord_q == 2'd2) ? ST_V_WR : ST_V_MLO;
      ST_V_WR:   state_d = ST_V_RD;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      lam_q        <= LambdaReset;
      sweeps_q     <= SweepReset;
      vcount_q     <= '0;
      edges_q      <= '0;
      sweep_left_q <= '0;
      vtx_q        <= '0;
      edge_q       <= '0;
      coord_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_MODE:   mode_q   <= cfg_data_i[0];
          CFG_LAMBDA: lam_q    <= cfg_data_i;
          CFG_SWEEPS: sweeps_q <= cfg_data_i[7:0];
          CFG_VCOUNT: vcount_q <= cfg_data_i[10:0];
          default: begin
          end
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && in_item_i.kind == KIND_EDGE && 32'(edges_q) < 32'(MAX_EDGES)) begin
            edges_q <= edges_q + EW'(1);
          end
          if (in_acc && in_item_i.kind == KIND_RUN) begin
            sweep_left_q <= sweeps_q;
            vtx_q        <= '0;
          end
        end
        ST_READ: out_valid_q <= 1'b1;
        ST_CLR: begin
          if (vtx_q < nv) begin
            vtx_q <= vtx_q + (VW + 1)'(1);
          end else begin
            edge_q <= '0;
          end
        end
        ST_E_RD:   if (edge_q >= edges_q) vtx_q <= '0;
        ST_E_POS:  if (!edge_ok) edge_q <= edge_q + EW'(1);
        ST_E_ACCB: edge_q <= edge_q + EW'(1);
        ST_V_RD: begin
          if (vtx_q >= nv) begin
            sweep_left_q <= sweep_left_q - 8'd1;
            vtx_q        <= '0;
          end
        end
        ST_V_CHK: begin
          if (movable && deg != '0) begin
            coord_q <= '0;
          end else begin
            vtx_q <= vtx_q + (VW + 1)'(1);
          end
        end
        ST_V_WAIT: if (div_done) coord_q <= coord_q + 2'd1;
        ST_V_WR:   vtx_q <= vtx_q + (VW + 1)'(1);
        ST_DONE:   out_valid_q <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc) begin
      rd_idx_q <= in_item_i.vertex_index;
      rd_ok_q  <= in_range;
    end
    if (state_q == ST_READ) begin
      out_item_q <= '{result_kind: 1'b0, out_index: rd_idx_q,
                      out_x: rd_ok_q ? pos_rd0_q.x : '0,
                      out_y: rd_ok_q ? pos_rd0_q.y : '0,
                      out_z: rd_ok_q ? pos_rd0_q.z : '0};
    end
    if (state_q == ST_DONE) begin
      out_item_q <= '{result_kind: 1'b1, out_index: '0, out_x: '0, out_y: '0,
                      out_z: '0};
    end
    if (state_q == ST_V_MLO) begin
      plo_q <= 40'(mag[23:0] * lam_mag);
      neg_q <= acc_c[AW-1] ^ lam_q[15];
    end
    if (state_q == ST_V_MHI) begin
      prod_q <= PW'(plo_q) + (PW'(mag[AW-1:24] * lam_mag) << 24);
    end
    if (state_q == ST_V_WAIT && div_done) begin
      case (coord_q)
        2'd0:    new_x_q <= rsat;
        2'd1:    new_y_q <= rsat;
        default: new_z_q <= rsat;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTH
  a_accept_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> state_q == ST_IDLE) else $error("command taken while busy");
  a_edge_distinct : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_E_ACCA |-> ea != eb) else $error("self loop accumulated");
  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_READ || $past(state_q) == ST_DONE))
    else $error("result beat from wrong state");
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ || state_q == ST_DONE) |-> !out_valid_q || !out_stall_i)
    else $error("pending result overwritten");
`endif

endmodule

/* tb/laplacian_mesh_smoother_top_tb.sv */
// ----------------------------------------------------------------------------
// Laplacian mesh smoother testbench
// Loads small meshes, runs Jacobi sweeps under several register settings and
// checks every read-back and run-finished beat against a predictor of the
// block, with random idling on the command and result channels.
// ----------------------------------------------------------------------------
module laplacian_mesh_smoother_top_tb;
  import lms_pkg::*;

  localparam int unsigned NumVerts  = 1024;
  localparam int unsigned NumEdges  = 4096;
  localparam int unsigned MeshSize  = 32;
  localparam int unsigned CycleCap  = 10000000;
  localparam int unsigned DrainWait = 60;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_item_t   in_item_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  laplacian_mesh_smoother_top uut (.*);

  always #1 clk_i = ~clk_i;

  // Predictor state.
  logic signed [31:0] pos_x_m [NumVerts];
  logic signed [31:0] pos_y_m [NumVerts];
  logic signed [31:0] pos_z_m [NumVerts];
  logic               bnd_m [NumVerts];
  logic [2:0]         regions_m [NumVerts];
  bit                 written_m [NumVerts];
  int unsigned        written_list [$];
  logic [9:0]         edge_a_m [NumEdges];
  logic [9:0]         edge_b_m [NumEdges];
  int unsigned        edge_total;
  logic               hull_mode;
  logic signed [15:0] gain;
  logic [7:0]         sweeps;
  logic [10:0]        vert_limit;

  out_item_t   pending_beats [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  bit          quiet = 1'b0;

  function automatic logic signed [31:0] moved_coord(input logic signed [31:0] old,
                                                     input longint acc,
                                                     input int unsigned deg,
                                                     input longint lam);
    longint num;
    longint unsigned den;
    longint unsigned mag;
    longint unsigned q;
    longint off;
    longint r;
    num = acc * lam;
    den = longint'(deg) * 16384;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag + den / 2) / den;
    off = (num < 0) ? -longint'(q) : longint'(q);
    r = longint'(old) + off;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  task automatic smooth_once();
    longint ax [NumVerts];
    longint ay [NumVerts];
    longint az [NumVerts];
    int unsigned deg [NumVerts];
    int unsigned n;
    int unsigned a;
    int unsigned b;
    bit movable;
    n = (vert_limit > NumVerts) ? NumVerts : vert_limit;
    for (int v = 0; v < NumVerts; v++) begin
      ax[v] = 0; ay[v] = 0; az[v] = 0; deg[v] = 0;
    end
    for (int e = 0; e < edge_total; e++) begin
      a = edge_a_m[e];
      b = edge_b_m[e];
      if (a >= n || b >= n || a == b) continue;
      ax[a] += longint'(pos_x_m[b]) - longint'(pos_x_m[a]);
      ay[a] += longint'(pos_y_m[b]) - longint'(pos_y_m[a]);
      az[a] += longint'(pos_z_m[b]) - longint'(pos_z_m[a]);
      deg[a]++;
      ax[b] += longint'(pos_x_m[a]) - longint'(pos_x_m[b]);
      ay[b] += longint'(pos_y_m[a]) - longint'(pos_y_m[b]);
      az[b] += longint'(pos_z_m[a]) - longint'(pos_z_m[b]);
      deg[b]++;
    end
    for (int v = 0; v < n; v++) begin
      movable = hull_mode ? (regions_m[v] == HullRegions) : (bnd_m[v] == 1'b0);
      if (!movable || deg[v] == 0) continue;
      pos_x_m[v] = moved_coord(pos_x_m[v], ax[v], deg[v], longint'(gain));
      pos_y_m[v] = moved_coord(pos_y_m[v], ay[v], deg[v], longint'(gain));
      pos_z_m[v] = moved_coord(pos_z_m[v], az[v], deg[v], longint'(gain));
    end
  endtask

  task automatic apply_command(input in_item_t it);
    out_item_t beat;
    beat = '0;
    case (lms_kind_e'(it.kind))
      KIND_WRITE: begin
        pos_x_m[it.vertex_index] = it.coord_x;
        pos_y_m[it.vertex_index] = it.coord_y;
        pos_z_m[it.vertex_index] = it.coord_z;
        bnd_m[it.vertex_index] = it.on_boundary;
        regions_m[it.vertex_index] = it.region_count;
        if (!written_m[it.vertex_index]) written_list.push_back(it.vertex_index);
        written_m[it.vertex_index] = 1'b1;
      end
      KIND_EDGE: begin
        if (edge_total < NumEdges) begin
          edge_a_m[edge_total] = it.vertex_index;
          edge_b_m[edge_total] = it.other_vertex;
          edge_total++;
        end
      end
      KIND_RUN: begin
        for (int s = 0; s < sweeps; s++) smooth_once();
        beat.result_kind = 1'b1;
        pending_beats.push_back(beat);
      end
      default: begin
        beat.out_index = it.vertex_index;
        beat.out_x = pos_x_m[it.vertex_index];
        beat.out_y = pos_y_m[it.vertex_index];
        beat.out_z = pos_z_m[it.vertex_index];
        pending_beats.push_back(beat);
      end
    endcase
  endtask

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_command(input in_item_t it);
    int unsigned gap;
    bit stalled;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    apply_command(it);
    items_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(input lms_cfg_e idx, input logic [15:0] d);
    bit ready;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do begin
      @(negedge clk_i);
      ready = cfg_ready_o;
      @(posedge clk_i);
    end while (!ready);
    case (idx)
      CFG_MODE:   hull_mode = d[0];
      CFG_LAMBDA: gain = d;
      CFG_SWEEPS: sweeps = d[7:0];
      default:    vert_limit = d[10:0];
    endcase
  endtask

  task automatic configure(input logic m, input logic [15:0] l, input logic [7:0] s,
                           input logic [10:0] n);
    settle();
    write_reg(CFG_MODE, {15'd0, m});
    write_reg(CFG_LAMBDA, l);
    write_reg(CFG_SWEEPS, {8'd0, s});
    write_reg(CFG_VCOUNT, {5'd0, n});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_item_t make_cmd(input lms_kind_e k, input int unsigned vi,
                                        input int unsigned ov, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] z,
                                        input logic b, input logic [2:0] r);
    in_item_t it;
    it.kind = k;
    it.vertex_index = 10'(vi);
    it.other_vertex = 10'(ov);
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    it.on_boundary = b;
    it.region_count = r;
    return it;
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return $signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
  endfunction

  task automatic put_vertex(input int unsigned vi, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic b, input logic [2:0] r);
    send_command(make_cmd(KIND_WRITE, vi, $urandom_range(0, 1023), x, y, z, b, r));
  endtask

  task automatic put_edge(input int unsigned a, input int unsigned b);
    send_command(make_cmd(KIND_EDGE, a, b, $urandom(), $urandom(), $urandom(),
                          1'($urandom_range(0, 1)), 3'($urandom_range(0, 7))));
  endtask

  task automatic ask_read(input int unsigned vi);
    send_command(make_cmd(KIND_READ, vi, $urandom_range(0, 1023), $urandom(), $urandom(),
                          $urandom(), 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7))));
  endtask

  task automatic ask_run();
    send_command(make_cmd(KIND_RUN, $urandom_range(0, 1023), $urandom_range(0, 1023),
                          $urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)),
                          3'($urandom_range(0, 7))));
  endtask

  task automatic test_directed_mesh();
    put_vertex(0, 32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b0, 3'd2);
    put_vertex(1, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0, 3'd2);
    put_vertex(2, 32'h00010000, 32'hFFFF0000, 32'h00008000, 1'b1, 3'd7);
    put_vertex(3, 32'h0, 32'h0, 32'h00030000, 1'b0, 3'd0);
    put_vertex(1023, 32'h12345678, 32'h0, 32'h0, 1'b1, 3'd1);
    put_edge(0, 1);
    put_edge(0, 1);
    put_edge(1, 2);
    put_edge(2, 2);
    put_edge(1023, 0);
    ask_read(1023);
    ask_run();
    ask_read(0);
    ask_read(1);
  endtask

  task automatic test_register_extremes();
    configure(1'b0, 16'h8000, 8'd1, 11'd4);
    ask_run();
    ask_read(0);
    configure(1'b1, 16'h7FFF, 8'd255, 11'd4);
    ask_run();
    ask_read(1);
    ask_read(3);
    configure(1'b0, 16'd8192, 8'd0, 11'd1024);
    ask_run();
    configure(1'b0, 16'd8192, 8'd1, 11'd0);
    ask_run();
    ask_read(2);
  endtask

  task automatic test_random_mesh();
    int unsigned roll;
    for (int v = 0; v < MeshSize; v++) begin
      put_vertex(v, rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 2) == 0,
                 ($urandom_range(0, 1) != 0) ? 3'd2 : 3'($urandom_range(0, 7)));
    end
    while (items_sent < 620) begin
      configure(1'($urandom_range(0, 1)), 16'($urandom()),
                ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 3)),
                11'($urandom_range(2, MeshSize)));
      repeat ($urandom_range(6, 16)) begin
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
          put_vertex(($urandom_range(0, 4) != 0) ? $urandom_range(0, MeshSize - 1)
                                                 : $urandom_range(0, 1023),
                     rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 2) == 0,
                     ($urandom_range(0, 1) != 0) ? 3'd2 : 3'($urandom_range(0, 7)));
        end else if (roll < 45) begin
          if ($urandom_range(0, 7) == 0) put_edge($urandom_range(0, 1023),
                                                  $urandom_range(0, 1023));
          else put_edge($urandom_range(0, MeshSize + 3), $urandom_range(0, MeshSize + 3));
        end else if (roll < 90) begin
          ask_read(written_list[$urandom_range(0, written_list.size() - 1)]);
        end else begin
          ask_run();
        end
      end
      ask_run();
    end
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    configure(1'b0, 16'd8192, 8'd1, 11'd32);
    put_edge(0, 3);
    put_edge(5, 6);
    ask_run();
    for (int v = 0; v < 8; v++) ask_read(v);
    settle();
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, out_item_o);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (out_item_o.result_kind !== want.result_kind) begin
          $display("%0t: result_kind expected %0d got %0d", $time, want.result_kind,
                   out_item_o.result_kind);
          errors++;
        end
        if (out_item_o.out_index !== want.out_index) begin
          $display("%0t: out_index expected %0d got %0d", $time, want.out_index,
                   out_item_o.out_index);
          errors++;
        end
        if (out_item_o.out_x !== want.out_x) begin
          $display("%0t: out_x expected %h got %h", $time, want.out_x, out_item_o.out_x);
          errors++;
        end
        if (out_item_o.out_y !== want.out_y) begin
          $display("%0t: out_y expected %h got %h", $time, want.out_y, out_item_o.out_y);
          errors++;
        end
        if (out_item_o.out_z !== want.out_z) begin
          $display("%0t: out_z expected %h got %h", $time, want.out_z, out_item_o.out_z);
          errors++;
        end
      end
    end
  end

  initial begin
    hull_mode = 1'b0;
    gain = LambdaReset;
    sweeps = SweepReset;
    vert_limit = '0;
    edge_total = 0;
    for (int v = 0; v < NumVerts; v++) written_m[v] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_mesh();
    test_register_extremes();
    test_random_mesh();
    test_quiet_tail();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
